// File: hw/rtl/symbol_hash_table_lookup_macros.svh
// ----------------------------------------------------------------------------
// symbol hash table lookup assertion macros
// Shared concurrent assertion forms for the lookup block.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_HASH_TABLE_LOOKUP_MACROS_SVH
`define SYMBOL_HASH_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SHTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SHTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/shtl_pkg.sv
// ----------------------------------------------------------------------------
// shtl_pkg
// Types, constants and helper functions of the symbol hash table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package shtl_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int NAME_BYTES_DEF    = 8;
    localparam int NAME_W            = 64;
    localparam int INDEX_OUT_W       = 8;
    localparam int SUM_W             = 11;

    localparam logic [14:0] HASH_MASK = 15'o77777;
    localparam logic [7:0]  BYTE_MASK = 8'o377;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] entry_index;
        logic                   created;
        logic                   entry_local;
        logic                   table_full;
    } t_result;

    // keep the low nbytes bytes up to the first zero byte, clear the rest
    function automatic logic [NAME_W-1:0] normalize_name(
        input logic [NAME_W-1:0] raw,
        input int                nbytes
    );
        logic [NAME_W-1:0] out;
        logic              keep;
        logic [7:0]        b;
        out  = '0;
        keep = 1'b1;
        for (int i = 0; i < NAME_W / 8; i++) begin
            b = raw[8*i +: 8] & BYTE_MASK;
            if (i >= nbytes || b == 8'd0) begin
                keep = 1'b0;
            end
            if (keep) begin
                out[8*i +: 8] = b;
            end
        end
        return out;
    endfunction

    // byte sum of a normalized name, masked to the hash width
    function automatic logic [SUM_W-1:0] name_sum(input logic [NAME_W-1:0] nm);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < NAME_W / 8; i++) begin
            s = s + SUM_W'(nm[8*i +: 8] & BYTE_MASK);
        end
        return s & HASH_MASK[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/shtl_mem.sv
// ----------------------------------------------------------------------------
// shtl_mem
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shtl_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 65,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/shtl_hash.sv
// ----------------------------------------------------------------------------
// shtl_hash
// Name hash: byte sum reduced modulo the table size. A power-of-two table
// keeps the low bits of the registered sum; any other size takes the
// remainder through a reciprocal multiply and a multiply-back subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module shtl_hash
    import shtl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = NAME_BYTES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NAME_W-1:0] i_name,
    output logic                   o_done,
    output logic      [IDX_W-1:0]  o_slot
);

    localparam int  HASH_W = $clog2(NAME_BYTES * 255 + 1);
    localparam bit  POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

    logic [SUM_W-1:0]        sum_in;
    logic [HASH_W-1:0]       r_rem;
    logic                    r_done;
    logic [HASH_W+IDX_W-1:0] rem_ext;

    assign sum_in  = name_sum(i_name);
    assign rem_ext = {{IDX_W{1'b0}}, r_rem};
    assign o_done  = r_done;

    generate
        if (POW2) begin : g_pow2
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= HASH_W'(sum_in);
                end
            end

            assign o_slot = rem_ext[IDX_W-1:0];
        end else begin : g_reduce
            // quotient = (sum * recip) >> shift, exact for every sum below 2**HASH_W
            localparam int     SHIFT   = HASH_W + IDX_W;
            localparam int     PROD_W  = SHIFT + HASH_W;
            localparam longint RECIP   = ((longint'(1) << SHIFT)
                                          + longint'(TABLE_ENTRIES) - 1)
                                         / longint'(TABLE_ENTRIES);
            localparam logic [HASH_W-1:0] T_LOW = HASH_W'(TABLE_ENTRIES);

            logic              r_mul;
            logic              r_sub;
            logic [HASH_W-1:0] r_quo;
            logic [PROD_W-1:0] prod;
            logic [HASH_W-1:0] back;

            assign prod = PROD_W'(r_rem) * PROD_W'(RECIP);
            // quotient times table size never exceeds the sum
            assign back = r_quo * T_LOW;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mul  <= 1'b0;
                    r_sub  <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_mul  <= i_start;
                    r_sub  <= r_mul;
                    r_done <= r_sub;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= HASH_W'(sum_in);
                end else if (r_sub) begin
                    r_rem <= r_rem - back;
                end
                if (r_mul) begin
                    r_quo <= prod[SHIFT +: HASH_W];
                end
            end

            assign o_slot = rem_ext[IDX_W-1:0];
        end
    endgenerate

endmodule

`default_nettype wire

// File: hw/rtl/symbol_hash_table_lookup.sv
// Find-or-insert symbol table with linear probing. After reset the block
// clears its entry RAM slot by slot and holds o_in_stall high meanwhile.
// One request is worked at a time, in steps: accept, hash (through the
// reduction steps when TABLE_ENTRIES is not a power of two), one probe per
// slot, and a load of the output register. The probe rate is set by the
// single registered read port of the entry RAM; a result waiting in the
// output register does not block the next request from being taken.
// ----------------------------------------------------------------------------
// symbol_hash_table_lookup
// Top level: request capture, probe sequencer, entry RAM and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_hash_table_lookup
    import shtl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [NAME_W-1:0] i_name,
    input  wire logic              i_local_scope,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [INDEX_OUT_W-1:0] o_entry_index,
    output logic                   o_created,
    output logic                   o_entry_local,
    output logic                   o_table_full
);

`include "symbol_hash_table_lookup_macros.svh"

    localparam int                IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int                NAME_BITS = 8 * NAME_BYTES;
    localparam int                ENT_W     = NAME_BITS + 1;
    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    t_state               r_state, n_state;
    logic [NAME_BITS-1:0] r_name;
    logic                 r_loc;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [IDX_W-1:0]     r_left, n_left;
    logic [IDX_W-1:0]     r_clr;
    t_result              r_res, n_res;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 in_xfer;
    logic                 out_free;
    logic                 load_out;
    logic [NAME_W-1:0]    name_norm;
    logic                 hash_done;
    logic [IDX_W-1:0]     hash_slot;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ENT_W-1:0]     wdata;
    logic [IDX_W-1:0]     raddr;
    logic [ENT_W-1:0]     rdata;

    logic [NAME_BITS-1:0] held_name;
    logic                 held_loc;
    logic                 slot_free;
    logic                 slot_match;
    logic [IDX_W-1:0]     slot_next;
    logic [IDX_W+7:0]     slot_ext;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign name_norm = normalize_name(i_name, NAME_BYTES);

    assign held_name  = rdata[NAME_BITS-1:0];
    assign held_loc   = rdata[NAME_BITS];
    assign slot_free  = (held_name[7:0] & BYTE_MASK) == 8'd0;
    assign slot_match = held_name == r_name;
    assign slot_next  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign slot_ext   = {8'd0, r_slot};

    shtl_hash #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_BYTES    (NAME_BYTES),
        .IDX_W         (IDX_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_name  (name_norm),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    shtl_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .DATA_W (ENT_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_left <= n_left;
        r_res  <= n_res;
        if (in_xfer) begin
            r_name <= name_norm[NAME_BITS-1:0];
            r_loc  <= i_local_scope;
        end
        if (load_out) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_left   = r_left;
        n_res    = r_res;
        raddr    = r_slot;
        we       = 1'b0;
        waddr    = r_slot;
        wdata    = {r_loc, r_name};
        load_out = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    raddr   = hash_slot;
                    n_slot  = hash_slot;
                    n_left  = LAST_SLOT;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // read data belongs to r_slot
                if (slot_free) begin
                    we      = 1'b1;
                    n_res   = '{entry_index: slot_ext[7:0], created: 1'b1,
                                entry_local: r_loc, table_full: 1'b0};
                    n_state = S_FINISH;
                end else if (slot_match) begin
                    n_res   = '{entry_index: slot_ext[7:0], created: 1'b0,
                                entry_local: held_loc, table_full: 1'b0};
                    n_state = S_FINISH;
                end else if (r_left == '0) begin
                    n_res   = '{entry_index: '0, created: 1'b0,
                                entry_local: 1'b0, table_full: 1'b1};
                    n_state = S_FINISH;
                end else begin
                    raddr  = slot_next;
                    n_slot = slot_next;
                    n_left = r_left - 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall    = r_state != S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_entry_index = r_out.entry_index;
    assign o_created     = r_out.created;
    assign o_entry_local = r_out.entry_local;
    assign o_table_full  = r_out.table_full;

    `SHTL_ASSERT_NXT(a_write_creates, i_clk, i_rst_n,
        we && r_state == S_PROBE, r_state == S_FINISH && r_res.created,
        "probe write did not produce a created result")
    `SHTL_ASSERT_IMP(a_hash_in_step, i_clk, i_rst_n,
        hash_done, r_state == S_HASH,
        "hash finished outside the hash step")
    `SHTL_ASSERT_IMP(a_full_not_created, i_clk, i_rst_n,
        r_out_valid, !(r_out.created && r_out.table_full),
        "result both created and table full")
    `SHTL_ASSERT_NXT(a_probe_countdown, i_clk, i_rst_n,
        r_state == S_PROBE && n_state == S_PROBE,
        r_left == $past(r_left) - 1'b1,
        "probe budget did not count down")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the symbol hash table lookup: a local table model
// predicts each find-or-insert, results are compared in order under random
// sender and receiver idling, from first inserts through a full table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import shtl_pkg::*;
();

    localparam int SLOTS        = TABLE_ENTRIES_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = SLOTS + 8;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [NAME_W-1:0]      i_name        = '0;
    logic                   i_local_scope = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [INDEX_OUT_W-1:0] o_entry_index;
    logic                   o_created;
    logic                   o_entry_local;
    logic                   o_table_full;

    // local copy of the table contents
    logic [NAME_W-1:0] table_names [SLOTS];
    logic              table_local [SLOTS];

    t_result           pending_results [$];
    logic [NAME_W-1:0] sent_names [$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                mismatches    = 0;
    int                quiet_cycles  = 0;

    symbol_hash_table_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_name        (i_name),
        .i_local_scope (i_local_scope),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_index (o_entry_index),
        .o_created     (o_created),
        .o_entry_local (o_entry_local),
        .o_table_full  (o_table_full)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // find-or-insert on the local table, returns the expected result
    function automatic t_result predict_lookup(input logic [NAME_W-1:0] raw,
                                               input logic loc);
        logic [NAME_W-1:0] nm;
        int                sum;
        int                start;
        int                slot;
        bit                cut;
        t_result           r;
        nm  = '0;
        sum = 0;
        cut = 1'b0;
        r   = '0;
        // bytes after the first zero byte do not count
        for (int i = 0; i < NAME_W / 8; i++) begin
            if (i >= NAME_BYTES_DEF || raw[8*i +: 8] == 8'd0) cut = 1'b1;
            if (!cut) begin
                nm[8*i +: 8] = raw[8*i +: 8];
                sum += raw[8*i +: 8];
            end
        end
        start = (sum & 32'h7fff) % SLOTS;
        for (int p = 0; p < SLOTS; p++) begin
            slot = (start + p) % SLOTS;
            if (table_names[slot][7:0] == 8'd0) begin
                table_names[slot] = nm;
                table_local[slot] = loc;
                r.entry_index = INDEX_OUT_W'(slot);
                r.created     = 1'b1;
                r.entry_local = loc;
                return r;
            end
            if (table_names[slot] == nm) begin
                r.entry_index = INDEX_OUT_W'(slot);
                r.entry_local = table_local[slot];
                return r;
            end
        end
        r.table_full = 1'b1;
        return r;
    endfunction

    // mostly zero-terminated names with junk past the end, some raw noise
    function automatic logic [NAME_W-1:0] random_name();
        logic [NAME_W-1:0] nm;
        int                kind;
        int                len;
        kind = $urandom_range(99);
        nm   = {$urandom(), $urandom()};
        len  = $urandom_range(1, 8);
        if (kind < 10) return nm;
        if (kind < 15) begin
            nm[7:0] = 8'd0;
            return nm;
        end
        for (int i = 0; i < NAME_W / 8; i++) begin
            if (i < len) nm[8*i +: 8] = 8'($urandom_range(1, 255));
            else if (i == len) nm[8*i +: 8] = 8'd0;
        end
        return nm;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_request(input logic [NAME_W-1:0] nm, input logic loc,
                                output t_result predicted);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid    <= 1'b0;
            i_name        <= {$urandom(), $urandom()};
            i_local_scope <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_name        <= nm;
        i_local_scope <= loc;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_lookup(nm, loc);
        pending_results.push_back(predicted);
        sent_names.push_back(nm);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_insert_and_find();
        t_result r;
        // "ab" and "ba" share a hash, the second probes one slot further
        send_request(64'h6261, 1'b1, r);
        send_request(64'h6162, 1'b0, r);
        send_request(64'h6261, 1'b0, r);
        send_request(64'h6162, 1'b1, r);
        wait_drained();
    endtask

    task automatic test_name_extremes();
        t_result r;
        send_request(64'hffff_ffff_ffff_ffff, 1'b1, r);
        send_request(64'h0000_0000_0000_0001, 1'b0, r);
        // junk after a zero byte is dropped, so the short name is then found
        send_request(64'h00ab_cd00_0000_4142, 1'b1, r);
        send_request(64'h0000_0000_0000_4142, 1'b0, r);
        send_request(64'h8000_0000_0000_0000, 1'b1, r);
        wait_drained();
    endtask

    task automatic test_empty_name();
        t_result r;
        // created every time, the slot never becomes used
        send_request(64'h0, 1'b1, r);
        send_request(64'hff00, 1'b0, r);
        send_request(64'h0, 1'b0, r);
        wait_drained();
    endtask

    task automatic test_probe_wrap();
        t_result r;
        send_request(64'h00ff, 1'b1, r);
        // same slot as the last one, probe wraps to slot 0
        send_request(64'h7f80, 1'b0, r);
        send_request(64'h01_ffff, 1'b1, r);
        send_request(64'h7f80, 1'b1, r);
        send_request(64'h0001, 1'b1, r);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        t_result           r;
        logic [NAME_W-1:0] nm;
        for (int n = 0; n < count; n++) begin
            if (sent_names.size() != 0 && $urandom_range(99) < 45)
                nm = sent_names[$urandom_range(sent_names.size() - 1)];
            else
                nm = random_name();
            send_request(nm, 1'($urandom_range(1)), r);
        end
    endtask

    task automatic test_table_full();
        t_result r;
        int      full_seen;
        full_seen = 0;
        for (int n = 0; n < 400 && full_seen < 8; n++) begin
            send_request(random_name(), 1'($urandom_range(1)), r);
            if (r.table_full) full_seen++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        got = {o_entry_index, o_created, o_entry_local, o_table_full};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d created %0b local %0b full %0b",
                             got.entry_index, got.created, got.entry_local,
                             got.table_full);
            end else begin
                want = pending_results.pop_front();
                if (got.entry_index !== want.entry_index || got.created !== want.created
                    || got.entry_local !== want.entry_local
                    || got.table_full !== want.table_full) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: expected index %0d created %0b local %0b full %0b, ",
                               want.entry_index, want.created, want.entry_local,
                               want.table_full);
                        $display("got index %0d created %0b local %0b full %0b",
                                 got.entry_index, got.created, got.entry_local,
                                 got.table_full);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            table_names[s] = '0;
            table_local[s] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 69;
        test_insert_and_find();
        test_name_extremes();
        test_empty_name();
        test_probe_wrap();
        test_random_traffic(350);
        wait_drained();

        send_idle_pct = 69;
        recv_idle_pct = 23;
        test_random_traffic(300);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_table_full();
        test_random_traffic(250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
